// ----- rtl/gtphx_pkg.sv -----
// Package for the Ethernet/IPv4/GTP-U header extractor.
// Holds the header window type, field codes and the field select and presence functions.
// No dependencies.
`default_nettype none

package gtphx_pkg;

  // Bytes of the header that any field reads (last field ends at offset 73)
  localparam int HDR_BYTES = 74;
  localparam int FIELD_COUNT = 24;
  localparam int FIELD_W = 48;
  localparam int CODE_W = 5;
  localparam int WINDOW_BYTES_DEF = 128;

  localparam logic [15:0] TUNNEL_PORT_RST = 16'd2152;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // Byte i of the header is hdr[i]
  typedef logic [HDR_BYTES-1:0][7:0] hdr_t;

  typedef enum logic [CODE_W-1:0] {
    FLD_DST_MAC       = 5'd0,
    FLD_SRC_MAC       = 5'd1,
    FLD_ETH_TYPE      = 5'd2,
    FLD_IP_SRC        = 5'd3,
    FLD_IP_DST        = 5'd4,
    FLD_IP_PROTO      = 5'd5,
    FLD_IP_TOS        = 5'd6,
    FLD_ICMP_CODE     = 5'd7,
    FLD_ICMP_TYPE     = 5'd8,
    FLD_ICMP_ID       = 5'd9,
    FLD_ICMP_SEQ      = 5'd10,
    FLD_ICMP_PAYLOAD  = 5'd11,
    FLD_TCP_SPORT     = 5'd12,
    FLD_TCP_DPORT     = 5'd13,
    FLD_UDP_SPORT     = 5'd14,
    FLD_UDP_DPORT     = 5'd15,
    FLD_GTP_TEID      = 5'd16,
    FLD_IN_IP_SRC     = 5'd17,
    FLD_IN_IP_DST     = 5'd18,
    FLD_IN_PROTO      = 5'd19,
    FLD_IN_TCP_SPORT  = 5'd20,
    FLD_IN_TCP_DPORT  = 5'd21,
    FLD_IN_UDP_SPORT  = 5'd22,
    FLD_IN_UDP_DPORT  = 5'd23
  } field_code_t;

  localparam logic [CODE_W-1:0] LAST_CODE = FLD_IN_UDP_DPORT;

  // Protocol classification of one packet
  typedef struct packed {
    logic icmp;
    logic tcp;
    logic udp;
    logic tunnel;
    logic in_tcp;
    logic in_udp;
  } pres_t;

  // Classify a captured header against the tunnel port
  function automatic pres_t classify(hdr_t h, logic [15:0] tunnel_port);
    pres_t p;
    p.icmp   = (h[23] == PROTO_ICMP);
    p.tcp    = (h[23] == PROTO_TCP);
    p.udp    = (h[23] == PROTO_UDP);
    p.tunnel = p.udp && ({h[36], h[37]} == tunnel_port);
    p.in_tcp = p.tunnel && (h[59] == PROTO_TCP);
    p.in_udp = p.tunnel && (h[59] == PROTO_UDP);
    return p;
  endfunction

  function automatic logic field_present(pres_t p, field_code_t c);
    logic r;
    case (c) inside
      [FLD_DST_MAC:FLD_IP_TOS]:          r = 1'b1;
      [FLD_ICMP_CODE:FLD_ICMP_PAYLOAD]:  r = p.icmp;
      [FLD_TCP_SPORT:FLD_TCP_DPORT]:     r = p.tcp;
      [FLD_UDP_SPORT:FLD_UDP_DPORT]:     r = p.udp;
      [FLD_GTP_TEID:FLD_IN_PROTO]:       r = p.tunnel;
      [FLD_IN_TCP_SPORT:FLD_IN_TCP_DPORT]: r = p.in_tcp;
      [FLD_IN_UDP_SPORT:FLD_IN_UDP_DPORT]: r = p.in_udp;
      default:                           r = 1'b0;
    endcase
    return r;
  endfunction

  // Big-endian value of a field at its fixed offset
  function automatic logic [FIELD_W-1:0] field_value(hdr_t h, field_code_t c);
    logic [FIELD_W-1:0] v;
    case (c)
      FLD_DST_MAC:      v = {h[0], h[1], h[2], h[3], h[4], h[5]};
      FLD_SRC_MAC:      v = {h[6], h[7], h[8], h[9], h[10], h[11]};
      FLD_ETH_TYPE:     v = {32'd0, h[12], h[13]};
      FLD_IP_SRC:       v = {16'd0, h[26], h[27], h[28], h[29]};
      FLD_IP_DST:       v = {16'd0, h[30], h[31], h[32], h[33]};
      FLD_IP_PROTO:     v = {40'd0, h[23]};
      FLD_IP_TOS:       v = {40'd0, h[15]};
      FLD_ICMP_CODE:    v = {40'd0, h[35]};
      FLD_ICMP_TYPE:    v = {40'd0, h[34]};
      FLD_ICMP_ID:      v = {32'd0, h[38], h[39]};
      FLD_ICMP_SEQ:     v = {32'd0, h[40], h[41]};
      FLD_ICMP_PAYLOAD: v = {16'd0, h[42], h[43], h[44], h[45]};
      FLD_TCP_SPORT:    v = {32'd0, h[34], h[35]};
      FLD_TCP_DPORT:    v = {32'd0, h[36], h[37]};
      FLD_UDP_SPORT:    v = {32'd0, h[34], h[35]};
      FLD_UDP_DPORT:    v = {32'd0, h[36], h[37]};
      FLD_GTP_TEID:     v = {16'd0, h[46], h[47], h[48], h[49]};
      FLD_IN_IP_SRC:    v = {16'd0, h[62], h[63], h[64], h[65]};
      FLD_IN_IP_DST:    v = {16'd0, h[66], h[67], h[68], h[69]};
      FLD_IN_PROTO:     v = {40'd0, h[59]};
      FLD_IN_TCP_SPORT: v = {32'd0, h[70], h[71]};
      FLD_IN_TCP_DPORT: v = {32'd0, h[72], h[73]};
      FLD_IN_UDP_SPORT: v = {32'd0, h[70], h[71]};
      FLD_IN_UDP_DPORT: v = {32'd0, h[72], h[73]};
      default:          v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/gtphx_if.sv -----
// Stream interfaces of the header extractor: packet byte channel and field result channel.
// Depends on gtphx_pkg for field widths.
`default_nettype none

interface gtphx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       end_of_packet;

  modport source (output valid, output packet_byte, output end_of_packet, input ready);
  modport sink (input valid, input packet_byte, input end_of_packet, output ready);
endinterface

interface gtphx_out_if;
  logic                               valid;
  logic                               ready;
  logic [gtphx_pkg::CODE_W-1:0]       field_code;
  logic [gtphx_pkg::FIELD_W-1:0]      field_value;
  logic                               field_present;
  logic                               last_field;

  modport source (output valid, output field_code, output field_value,
                  output field_present, output last_field, input ready);
  modport sink (input valid, input field_code, input field_value,
                input field_present, input last_field, output ready);
endinterface

`default_nettype wire

// ----- rtl/gtphx_capture.sv -----
// Byte capture: input register, header window and byte counter.
// Hands a masked header snapshot to the emitter at packet end. Depends on gtphx_pkg.
`default_nettype none

module gtphx_capture #(
  parameter int WINDOW_BYTES = gtphx_pkg::WINDOW_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  gtphx_in_if.sink         in_ch,
  input  wire logic        snap_free,
  output logic             snap_load,
  output gtphx_pkg::hdr_t  snap_hdr
);

  localparam int CW = $clog2(WINDOW_BYTES + 1);

  logic          s1_valid_r;
  logic [7:0]    s1_byte_r;
  logic          s1_eop_r;
  logic          s1_fire;
  logic [CW-1:0] pos_r;
  logic [CW-1:0] pos_nxt;
  gtphx_pkg::hdr_t win_r;

  // Advance the held beat; an end-of-packet beat waits for a free snapshot
  assign s1_fire   = s1_valid_r && (!s1_eop_r || snap_free);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign snap_load = s1_fire && s1_eop_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.packet_byte;
      s1_eop_r  <= in_ch.end_of_packet;
    end
  end

  // Byte counter: saturate at the window size, restart after packet end
  always_comb begin
    pos_nxt = pos_r;
    if (s1_fire) begin
      if (s1_eop_r) begin
        pos_nxt = '0;
      end else if (pos_r < CW'(WINDOW_BYTES)) begin
        pos_nxt = pos_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Window: store the byte at its position; only the header bytes are kept
  always_ff @(posedge clk) begin
    for (int i = 0; i < gtphx_pkg::HDR_BYTES; i++) begin
      if (s1_fire && !s1_eop_r && pos_r == CW'(i)) begin
        win_r[i] <= s1_byte_r;
      end
    end
  end

  // Snapshot: bytes not yet received this packet read as zero
  always_comb begin
    for (int i = 0; i < gtphx_pkg::HDR_BYTES; i++) begin
      if (CW'(i) < pos_r) begin
        snap_hdr[i] = win_r[i];
      end else if (CW'(i) == pos_r) begin
        snap_hdr[i] = s1_byte_r;
      end else begin
        snap_hdr[i] = 8'd0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gtphx_emit.sv -----
// Field emitter: holds one packet's header, walks the 24 field codes into an output register.
// Depends on gtphx_pkg.
`default_nettype none

module gtphx_emit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             snap_load,
  input  wire gtphx_pkg::hdr_t  snap_hdr,
  input  wire logic [15:0]      tunnel_port,
  output logic                  snap_free,
  gtphx_out_if.source           out_ch
);

  logic                             busy_r;
  logic [gtphx_pkg::CODE_W-1:0]     idx_r;
  gtphx_pkg::hdr_t                  hdr_r;
  gtphx_pkg::pres_t                 pres_r;
  logic                             advance;
  logic                             at_last;
  logic                             out_valid_r;
  logic [gtphx_pkg::CODE_W-1:0]     code_r;
  logic [gtphx_pkg::FIELD_W-1:0]    value_r;
  logic                             present_r;
  logic                             last_r;
  logic                             cur_present;
  gtphx_pkg::field_code_t           cur_code;

  assign cur_code    = gtphx_pkg::field_code_t'(idx_r);
  assign cur_present = gtphx_pkg::field_present(pres_r, cur_code);
  assign at_last     = (idx_r == gtphx_pkg::LAST_CODE);
  assign advance     = busy_r && (!out_valid_r || out_ch.ready);
  assign snap_free   = !busy_r || (advance && at_last);

  // Sequence control: load a new header, step through the codes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (snap_load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (advance) begin
      busy_r <= !at_last;
      idx_r  <= idx_r + gtphx_pkg::CODE_W'(1);
    end
  end

  // Header and classification of the packet being emitted
  always_ff @(posedge clk) begin
    if (snap_load) begin
      hdr_r  <= snap_hdr;
      pres_r <= gtphx_pkg::classify(snap_hdr, tunnel_port);
    end
  end

  // Output register: hold a beat until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      code_r    <= idx_r;
      value_r   <= cur_present ? gtphx_pkg::field_value(hdr_r, cur_code) : '0;
      present_r <= cur_present;
      last_r    <= at_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.field_code    = code_r;
  assign out_ch.field_value   = value_r;
  assign out_ch.field_present = present_r;
  assign out_ch.last_field    = last_r;

endmodule

`default_nettype wire

// ----- rtl/eth_ipv4_gtp_header_extractor.sv -----
// Top level of the Ethernet/IPv4/GTP-U header extractor: config register, capture, emitter.
// Depends on gtphx_pkg, gtphx_if, gtphx_capture and gtphx_emit.
//
//   channel  direction  beat
//   in_ch    sink       packet_byte, end_of_packet
//   out_ch   source     field_code, field_value, field_present, last_field
//   cfg_*    write      tunnel_udp_port (16 bit)
//
// Packet bytes are taken one per cycle. A packet end yields 24 beats, one per cycle while
// out_ch is ready, from a one-packet snapshot; the next packet streams in meanwhile.
// An end-of-packet byte stalls in the input register only while the previous packet
// still has beats to send (packets shorter than 24 bytes back to back).
// Reset (rst_n, synchronous) clears the pipeline, byte counter and sets the port to 2152.
`default_nettype none

module eth_ipv4_gtp_header_extractor #(
  parameter int WINDOW_BYTES = gtphx_pkg::WINDOW_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  gtphx_in_if.sink         in_ch,
  gtphx_out_if.source      out_ch,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  logic [15:0]     tunnel_port_r;
  logic            snap_free;
  logic            snap_load;
  gtphx_pkg::hdr_t snap_hdr;

  // Tunnel port register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tunnel_port_r <= gtphx_pkg::TUNNEL_PORT_RST;
    end else if (cfg_wr_en) begin
      tunnel_port_r <= cfg_wr_data;
    end
  end

  gtphx_capture #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .snap_free (snap_free),
    .snap_load (snap_load),
    .snap_hdr  (snap_hdr)
  );

  gtphx_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .snap_load   (snap_load),
    .snap_hdr    (snap_hdr),
    .tunnel_port (tunnel_port_r),
    .snap_free   (snap_free),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

// ----- sim/tb_eth_ipv4_gtp_header_extractor.sv -----
`timescale 1ns / 1ps
// Testbench for eth_ipv4_gtp_header_extractor: streams Ethernet/IPv4/GTP-U frames byte by byte
// and checks the 24 field beats of every frame against a built-in field predictor.
// Depends on gtphx_pkg, gtphx_if and the extractor RTL.

module tb_eth_ipv4_gtp_header_extractor;

  // Smallest legal window: every header byte fits, one more byte already overflows
  localparam int WIN_BYTES = gtphx_pkg::HDR_BYTES;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_FRAMES = 4;
  localparam int RANDOM_MAX_LEN = 40;
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0] IPV4_VER_IHL = 8'h45;

  typedef struct packed {
    logic [gtphx_pkg::CODE_W-1:0]  code;
    logic [gtphx_pkg::FIELD_W-1:0] value;
    logic                          present;
    logic                          last;
  } field_beat_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        src_valid = 1'b0;
  logic [7:0]  src_byte = 8'd0;
  logic        src_eop = 1'b0;
  logic        sink_ready = 1'b0;
  logic        cfg_en = 1'b0;
  logic [15:0] cfg_data = 16'd0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;

  // Predictor state: captured header bytes, fill count and tunnel port
  logic [7:0]  hdr_win [WIN_BYTES] = '{default: 8'd0};
  int          hdr_fill = 0;
  logic [15:0] tunnel_port = gtphx_pkg::TUNNEL_PORT_RST;

  field_beat_t pending_fields [$];
  logic [7:0]  frame_q [$];

  gtphx_in_if  in_ch ();
  gtphx_out_if out_ch ();

  assign in_ch.valid         = src_valid;
  assign in_ch.packet_byte   = src_byte;
  assign in_ch.end_of_packet = src_eop;
  assign out_ch.ready        = sink_ready;

  eth_ipv4_gtp_header_extractor #(
    .WINDOW_BYTES(WIN_BYTES)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_en),
    .cfg_wr_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    sink_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Header byte as captured; bytes past the window read as zero
  function automatic logic [7:0] win_at(input int idx);
    return (idx < WIN_BYTES) ? hdr_win[idx] : 8'd0;
  endfunction

  function automatic logic [gtphx_pkg::FIELD_W-1:0] be_read(input int off, input int len);
    logic [gtphx_pkg::FIELD_W-1:0] v;
    v = '0;
    for (int i = 0; i < len; i++) v = {v[gtphx_pkg::FIELD_W-9:0], win_at(off + i)};
    return v;
  endfunction

  function automatic void field_span(input gtphx_pkg::field_code_t code, output int off,
                                     output int len);
    case (code)
      gtphx_pkg::FLD_DST_MAC:      begin off = 0;  len = 6; end
      gtphx_pkg::FLD_SRC_MAC:      begin off = 6;  len = 6; end
      gtphx_pkg::FLD_ETH_TYPE:     begin off = 12; len = 2; end
      gtphx_pkg::FLD_IP_SRC:       begin off = 26; len = 4; end
      gtphx_pkg::FLD_IP_DST:       begin off = 30; len = 4; end
      gtphx_pkg::FLD_IP_PROTO:     begin off = 23; len = 1; end
      gtphx_pkg::FLD_IP_TOS:       begin off = 15; len = 1; end
      gtphx_pkg::FLD_ICMP_CODE:    begin off = 35; len = 1; end
      gtphx_pkg::FLD_ICMP_TYPE:    begin off = 34; len = 1; end
      gtphx_pkg::FLD_ICMP_ID:      begin off = 38; len = 2; end
      gtphx_pkg::FLD_ICMP_SEQ:     begin off = 40; len = 2; end
      gtphx_pkg::FLD_ICMP_PAYLOAD: begin off = 42; len = 4; end
      gtphx_pkg::FLD_TCP_SPORT,
      gtphx_pkg::FLD_UDP_SPORT:    begin off = 34; len = 2; end
      gtphx_pkg::FLD_TCP_DPORT,
      gtphx_pkg::FLD_UDP_DPORT:    begin off = 36; len = 2; end
      gtphx_pkg::FLD_GTP_TEID:     begin off = 46; len = 4; end
      gtphx_pkg::FLD_IN_IP_SRC:    begin off = 62; len = 4; end
      gtphx_pkg::FLD_IN_IP_DST:    begin off = 66; len = 4; end
      gtphx_pkg::FLD_IN_PROTO:     begin off = 59; len = 1; end
      gtphx_pkg::FLD_IN_TCP_SPORT,
      gtphx_pkg::FLD_IN_UDP_SPORT: begin off = 70; len = 2; end
      gtphx_pkg::FLD_IN_TCP_DPORT,
      gtphx_pkg::FLD_IN_UDP_DPORT: begin off = 72; len = 2; end
      default:                     begin off = 0;  len = 0; end
    endcase
  endfunction

  // Capture one accepted byte; on end of packet queue the 24 field beats and clear
  task automatic predict_fields(input logic [7:0] b, input logic eop);
    logic [7:0]             proto;
    logic [7:0]             inner;
    logic                   tunnel;
    logic                   present;
    gtphx_pkg::field_code_t code;
    int                     off;
    int                     len;
    field_beat_t            fb;
    if (hdr_fill < WIN_BYTES) begin
      hdr_win[hdr_fill] = b;
      hdr_fill++;
    end
    if (eop) begin
      proto  = win_at(23);
      inner  = win_at(59);
      tunnel = (proto == gtphx_pkg::PROTO_UDP) && (be_read(36, 2) == {32'd0, tunnel_port});
      for (int k = 0; k < gtphx_pkg::FIELD_COUNT; k++) begin
        code = gtphx_pkg::field_code_t'(k);
        if (code <= gtphx_pkg::FLD_IP_TOS) present = 1'b1;
        else if (code <= gtphx_pkg::FLD_ICMP_PAYLOAD) present = (proto == gtphx_pkg::PROTO_ICMP);
        else if (code <= gtphx_pkg::FLD_TCP_DPORT) present = (proto == gtphx_pkg::PROTO_TCP);
        else if (code <= gtphx_pkg::FLD_UDP_DPORT) present = (proto == gtphx_pkg::PROTO_UDP);
        else if (code <= gtphx_pkg::FLD_IN_PROTO) present = tunnel;
        else if (code <= gtphx_pkg::FLD_IN_TCP_DPORT)
          present = tunnel && (inner == gtphx_pkg::PROTO_TCP);
        else present = tunnel && (inner == gtphx_pkg::PROTO_UDP);
        field_span(code, off, len);
        fb.code    = code;
        fb.value   = present ? be_read(off, len) : '0;
        fb.present = present;
        fb.last    = (code == gtphx_pkg::LAST_CODE);
        pending_fields.push_back(fb);
      end
      hdr_fill = 0;
      for (int i = 0; i < WIN_BYTES; i++) hdr_win[i] = 8'd0;
    end
  endtask

  // Compare each accepted field beat with the oldest pending one
  always @(posedge clk) begin : check_fields
    field_beat_t want;
    if (rst_n && out_ch.valid && sink_ready) begin
      if (pending_fields.size() == 0) begin
        $error("unexpected field beat, field_code %0d", out_ch.field_code);
        fail_count++;
      end else begin
        want = pending_fields.pop_front();
        if (out_ch.field_code !== want.code) begin
          $error("field_code: expected %0d, got %0d", want.code, out_ch.field_code);
          fail_count++;
        end
        if (out_ch.field_value !== want.value) begin
          $error("field_value: expected %0h, got %0h", want.value, out_ch.field_value);
          fail_count++;
        end
        if (out_ch.field_present !== want.present) begin
          $error("field_present: expected %0b, got %0b", want.present, out_ch.field_present);
          fail_count++;
        end
        if (out_ch.last_field !== want.last) begin
          $error("last_field: expected %0b, got %0b", want.last, out_ch.last_field);
          fail_count++;
        end
      end
    end
  end

  // End the run when neither channel moves a beat for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if (!rst_n || (src_valid && in_ch.ready) || (out_ch.valid && sink_ready)) quiet = 0;
      else quiet++;
    end
    $display("eth_ipv4_gtp_header_extractor regression: fail");
    $finish;
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Drive one byte beat, with a random gap ahead of it, and hold it until taken
  task automatic send_beat(input logic [7:0] b, input logic eop);
    if ($urandom_range(99) < send_idle_pct) begin
      src_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    src_valid <= 1'b1;
    src_byte  <= b;
    src_eop   <= eop;
    do @(posedge clk); while (!in_ch.ready);
    predict_fields(b, eop);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_beat(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Hold the sender off until every pending field beat has come out
  task automatic drain_fields();
    src_valid <= 1'b0;
    do @(posedge clk); while (pending_fields.size() != 0);
  endtask

  task automatic write_tunnel_port(input logic [15:0] port);
    drain_fields();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_en   <= 1'b1;
    cfg_data <= port;
    @(posedge clk);
    cfg_en <= 1'b0;
    tunnel_port = port;
  endtask

  // Overwrite a frame byte if the frame is long enough to hold it
  function automatic void put_byte(input int idx, input logic [7:0] val);
    if (idx < frame_q.size()) frame_q[idx] = val;
  endfunction

  task automatic make_const_frame(input int len, input logic [7:0] val);
    frame_q.delete();
    repeat (len) frame_q.push_back(val);
  endtask

  // Random content with the classifying bytes set: protocol, UDP dport, inner protocol
  task automatic make_frame(input int len, input logic [7:0] proto, input logic [15:0] dport,
                            input logic [7:0] inner);
    frame_q.delete();
    repeat (len) frame_q.push_back(8'($urandom_range(255)));
    put_byte(12, ETH_TYPE_IPV4[15:8]);
    put_byte(13, ETH_TYPE_IPV4[7:0]);
    put_byte(14, IPV4_VER_IHL);
    put_byte(23, proto);
    put_byte(36, dport[15:8]);
    put_byte(37, dport[7:0]);
    put_byte(58, IPV4_VER_IHL);
    put_byte(59, inner);
  endtask

  task automatic send_random_frame();
    int          kind;
    int          len;
    int          pick;
    logic [7:0]  proto;
    logic [7:0]  inner;
    logic [15:0] dport;
    kind = $urandom_range(99);
    len = $urandom_range(RANDOM_MAX_LEN, 1);
    pick = $urandom_range(99);
    if (pick < 20) proto = gtphx_pkg::PROTO_ICMP;
    else if (pick < 40) proto = gtphx_pkg::PROTO_TCP;
    else if (pick < 85) proto = gtphx_pkg::PROTO_UDP;
    else proto = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 60) dport = tunnel_port;
    else if (pick < 80) dport = tunnel_port ^ (16'd1 << $urandom_range(15));
    else dport = 16'($urandom_range(65535));
    pick = $urandom_range(99);
    if (pick < 40) inner = gtphx_pkg::PROTO_TCP;
    else if (pick < 80) inner = gtphx_pkg::PROTO_UDP;
    else inner = 8'($urandom_range(255));
    if (kind >= 88) begin
      // noise: no structure at all
      frame_q.delete();
      repeat (len) frame_q.push_back(8'($urandom_range(255)));
    end else begin
      make_frame(len, proto, dport, inner);
    end
    send_frame();
  endtask

  // All-zero and all-one frames (the latter with a UDP protocol byte) at the reset tunnel port
  task automatic test_field_extremes();
    set_idling(0, 0);
    make_const_frame(12, 8'h00);
    send_frame();
    make_const_frame(38, 8'hFF);
    put_byte(23, gtphx_pkg::PROTO_UDP);
    send_frame();
  endtask

  // ICMP in full and a tunnel carrying TCP
  task automatic test_protocols();
    set_idling(20, 20);
    make_frame(46, gtphx_pkg::PROTO_ICMP, 16'($urandom_range(65535)), 8'($urandom_range(255)));
    send_frame();
    make_frame(gtphx_pkg::HDR_BYTES, gtphx_pkg::PROTO_UDP, tunnel_port, gtphx_pkg::PROTO_TCP);
    send_frame();
  endtask

  // Truncated frames read missing bytes as zero; bytes past the window are dropped
  task automatic test_frame_lengths();
    set_idling(67, 0);
    make_frame(1, gtphx_pkg::PROTO_UDP, tunnel_port, gtphx_pkg::PROTO_UDP);
    send_frame();
    make_frame(WIN_BYTES + 1, gtphx_pkg::PROTO_UDP, tunnel_port, gtphx_pkg::PROTO_UDP);
    send_frame();
  endtask

  // Tiny frames back to back stall the input while the previous fields drain
  task automatic test_back_to_back_short();
    set_idling(0, 67);
    make_frame(1, gtphx_pkg::PROTO_UDP, tunnel_port, gtphx_pkg::PROTO_UDP);
    send_frame();
    make_frame(2, gtphx_pkg::PROTO_UDP, tunnel_port, gtphx_pkg::PROTO_UDP);
    send_frame();
    make_frame(3, gtphx_pkg::PROTO_UDP, tunnel_port, gtphx_pkg::PROTO_UDP);
    send_frame();
    make_frame(1, gtphx_pkg::PROTO_UDP, tunnel_port, gtphx_pkg::PROTO_UDP);
    send_frame();
  endtask

  // Tunnel port at both ends of its range
  task automatic test_tunnel_port_extremes();
    set_idling(0, 0);
    write_tunnel_port(16'h0000);
    // dport low byte never arrives, so it reads as zero and matches
    make_frame(37, gtphx_pkg::PROTO_UDP, 16'h0055, gtphx_pkg::PROTO_TCP);
    send_frame();
    write_tunnel_port(16'hFFFF);
    make_const_frame(50, 8'hFF);
    put_byte(23, gtphx_pkg::PROTO_UDP);
    send_frame();
  endtask

  // Mostly well-formed frames across the idling phases, new tunnel port per phase
  task automatic test_random_traffic();
    int per_phase;
    per_phase = RANDOM_FRAMES / 4;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_idling(0, 0);
        1: set_idling(67, 0);
        2: set_idling(0, 67);
        default: set_idling(20, 20);
      endcase
      write_tunnel_port((ph == 0) ? gtphx_pkg::TUNNEL_PORT_RST : 16'($urandom_range(65535)));
      for (int n = 0; n < per_phase; n++) begin
        if (ph == 3 && n == per_phase / 2) drain_fields();
        send_random_frame();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_protocols();
    test_frame_lengths();
    test_back_to_back_short();
    test_tunnel_port_extremes();
    test_random_traffic();
    drain_fields();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("eth_ipv4_gtp_header_extractor regression: pass");
    end else begin
      $display("eth_ipv4_gtp_header_extractor regression: fail");
    end
    $finish;
  end

endmodule
